// ----- src/n2a_pkg.sv -----
`timescale 1ns / 1ps

package n2a_pkg;

    // Format request codes
    localparam logic [1:0] REQ_DEC = 2'd0;
    localparam logic [1:0] REQ_HEX = 2'd1;
    localparam logic [1:0] REQ_FIX = 2'd2;

    // Payload widths
    localparam int unsigned IN_BITS   = 32;
    localparam int unsigned CHAR_BITS = 7;

    // Largest value shown in the fixed 999.9 format
    localparam logic [IN_BITS-1:0] FIX_LIMIT = 32'd9999;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_BITS-1:0] CH_UA    = 7'h41;
    localparam logic [CHAR_BITS-1:0] CH_STAR  = 7'h2A;
    localparam logic [CHAR_BITS-1:0] CH_DOT   = 7'h2E;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 7'h20;

    // One digit (0..15) to its ASCII character, uppercase for A..F
    function automatic logic [CHAR_BITS-1:0] f_digit_char(input logic [3:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {3'b000, d};
        end else begin
            c = CH_UA + {3'b000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

// ----- src/n2a_if.sv -----
`timescale 1ns / 1ps

// Conversion request channel
interface n2a_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// Character channel
interface n2a_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- src/number_to_ascii_formatter.sv -----
`timescale 1ns / 1ps

// Converts an unsigned value to ASCII, most significant character first, with
// last_char set on the final character of each run. req_type 0 gives decimal
// without leading zeros, 1 uppercase hex without leading zeros, 2 the fixed
// 999.9 format (value read as tenths, trailing space, "***.* " above 9999);
// code 3 is accepted and yields nothing. One request is handled at a time.
// Decimal and fixed requests wait on a bit-serial BCD converter that takes one
// input bit per cycle; leading zeros are then dropped and the characters sent.
// Hex requests and overflowing fixed requests skip the converter. The next
// request is taken once the last character sits in the output register.
module number_to_ascii_formatter
    import n2a_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    n2a_in_if.sink    i_in,
    n2a_out_if.source o_out
);

    localparam int unsigned EW   = (VALUE_BITS > IN_BITS) ? IN_BITS : VALUE_BITS;
    localparam int unsigned ND   = ((EW * 1233) >> 12) + 1;
    localparam int unsigned NDIG = (ND < 4) ? 4 : ND;
    localparam int unsigned NH   = (EW + 3) / 4;
    localparam int unsigned PW   = $clog2(NDIG);
    localparam logic [IN_BITS-1:0] VMASK = 32'hFFFF_FFFF >> (IN_BITS - EW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_DIGIT,
        S_DOT,
        S_FRAC,
        S_SPACE
    } t_state;

    t_state              r_state, n_state;
    logic [4*NDIG-1:0]   r_val, n_val;
    logic [PW-1:0]       r_pos, n_pos;
    logic                r_hex, n_hex;
    logic                r_fix, n_fix;
    logic                r_ovf, n_ovf;
    logic                r_ovalid, n_ovalid;
    logic [CHAR_BITS-1:0] r_char, n_char;
    logic                r_last, n_last;

    logic [IN_BITS-1:0]  vm;
    logic                dab_start;
    logic                dab_busy;
    logic [4*NDIG-1:0]   bcd;
    logic [3:0]          digit;
    logic [PW-1:0]       pos_min;
    logic                out_free;
    logic                in_take;

    n2a_dabble #(
        .W    (EW),
        .NDIG (NDIG)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dab_start),
        .i_value (vm[EW-1:0]),
        .o_busy  (dab_busy),
        .o_bcd   (bcd)
    );

    assign vm       = i_in.value & VMASK;
    assign in_take  = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || o_out.ready;
    assign digit    = r_hex ? r_val[4*r_pos +: 4] : bcd[4*r_pos +: 4];
    assign pos_min  = r_fix ? PW'(1) : '0;

    // Sequencer and output register
    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_pos     = r_pos;
        n_hex     = r_hex;
        n_fix     = r_fix;
        n_ovf     = r_ovf;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_char    = r_char;
        n_last    = r_last;
        dab_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_val = {{(4*NDIG-EW){1'b0}}, vm[EW-1:0]};
                    n_hex = 1'b0;
                    n_fix = 1'b0;
                    n_ovf = 1'b0;
                    unique case (i_in.req_type)
                        REQ_DEC: begin
                            dab_start = 1'b1;
                            n_pos     = PW'(ND - 1);
                            n_state   = S_CONV;
                        end
                        REQ_HEX: begin
                            n_hex   = 1'b1;
                            n_pos   = PW'(NH - 1);
                            n_state = S_SKIP;
                        end
                        REQ_FIX: begin
                            n_fix = 1'b1;
                            n_pos = PW'(3);
                            if (vm > FIX_LIMIT) begin
                                n_ovf   = 1'b1;
                                n_state = S_DIGIT;
                            end else begin
                                dab_start = 1'b1;
                                n_state   = S_CONV;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV: begin
                if (!dab_busy) begin
                    n_state = S_SKIP;
                end
            end
            // drop leading zeros, one digit a cycle
            S_SKIP: begin
                if (r_pos > pos_min && digit == 4'd0) begin
                    n_pos = r_pos - 1'b1;
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = r_ovf ? CH_STAR : f_digit_char(digit);
                    n_last   = !r_fix && (r_pos == '0);
                    if (r_pos == pos_min) begin
                        n_state = r_fix ? S_DOT : S_IDLE;
                    end else begin
                        n_pos = r_pos - 1'b1;
                    end
                end
            end
            S_DOT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CH_DOT;
                    n_last   = 1'b0;
                    n_state  = S_FRAC;
                end
            end
            // tenths digit
            S_FRAC: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = r_ovf ? CH_STAR : f_digit_char(bcd[3:0]);
                    n_last   = 1'b0;
                    n_state  = S_SPACE;
                end
            end
            S_SPACE: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CH_SPACE;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_val  <= n_val;
        r_pos  <= n_pos;
        r_hex  <= n_hex;
        r_fix  <= n_fix;
        r_ovf  <= n_ovf;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.char_code = r_char;
    assign o_out.last_char = r_last;

endmodule

// ----- src/n2a_dabble.sv -----
`timescale 1ns / 1ps

// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle
module n2a_dabble #(
    parameter int unsigned W    = 32,
    parameter int unsigned NDIG = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [W-1:0]      i_value,
    output logic              o_busy,
    output logic [4*NDIG-1:0] o_bcd
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]      r_shift, n_shift;
    logic [4*NDIG-1:0] r_bcd, n_bcd;
    logic [4*NDIG-1:0] adj;
    logic [CW-1:0]     r_cnt, n_cnt;

    // Add 3 to every digit that is 5 or more before the shift
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    // Step control
    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        if (i_start) begin
            n_shift = i_value;
            n_bcd   = '0;
            n_cnt   = CW'(W);
        end else if (r_cnt != '0) begin
            n_bcd   = {adj[4*NDIG-2:0], r_shift[W-1]};
            n_shift = {r_shift[W-2:0], 1'b0};
            n_cnt   = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
    end

    assign o_busy = (r_cnt != '0);
    assign o_bcd  = r_bcd;

endmodule

// ----- tb/n2a_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the formatter, works out the characters each
// accepted request should produce and compares every character taken from
// the output against the oldest one still owed.
module n2a_checker
    import n2a_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    n2a_in_if           i_req_ch,
    n2a_out_if          i_char_ch,
    output int unsigned o_pending,
    output int unsigned o_errors
);

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 is_last;
    } t_char;

    t_char       owed_chars[$];
    t_char       want;
    int unsigned pending_count = 0;
    int unsigned err_count     = 0;

    assign o_pending = pending_count;
    assign o_errors  = err_count;

    // digit 0..15 as ASCII, uppercase letters above nine
    function automatic logic [CHAR_BITS-1:0] ascii_digit(input int unsigned d);
        if (d < 10) begin
            return 7'(8'h30 + d);
        end
        return 7'(8'h41 + d - 10);
    endfunction

    // Queue the character run that one request should produce
    task automatic owe_chars(input logic [1:0] kind, input logic [31:0] raw);
        logic [CHAR_BITS-1:0] text [0:11];
        logic [CHAR_BITS-1:0] rev  [0:11];
        logic [63:0]          mask;
        logic [31:0]          v;
        int unsigned          radix;
        int unsigned          whole;
        int unsigned          n;
        int unsigned          k;
        mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
        v    = raw & mask[31:0];
        n    = 0;
        case (kind)
            REQ_DEC, REQ_HEX: begin
                radix = (kind == REQ_DEC) ? 10 : 16;
                do begin
                    rev[n] = ascii_digit(v % radix);
                    v      = v / radix;
                    n      = n + 1;
                end while (v != 0);
                for (k = 0; k < n; k++) begin
                    text[k] = rev[n - 1 - k];
                end
            end
            REQ_FIX: begin
                if (v > FIX_LIMIT) begin
                    // overflow shows as stars
                    text[0] = CH_STAR;
                    text[1] = CH_STAR;
                    text[2] = CH_STAR;
                    text[3] = CH_DOT;
                    text[4] = CH_STAR;
                    text[5] = CH_SPACE;
                    n = 6;
                end else begin
                    whole = v / 10;
                    if (whole >= 100) begin
                        text[n] = ascii_digit(whole / 100);
                        n = n + 1;
                    end
                    if (whole >= 10) begin
                        text[n] = ascii_digit((whole / 10) % 10);
                        n = n + 1;
                    end
                    text[n]     = ascii_digit(whole % 10);
                    text[n + 1] = CH_DOT;
                    text[n + 2] = ascii_digit(v % 10);
                    text[n + 3] = CH_SPACE;
                    n = n + 4;
                end
            end
            default: begin
                // unused code: nothing comes out
            end
        endcase
        for (k = 0; k < n; k++) begin
            owed_chars.push_back('{code: text[k], is_last: (k == n - 1)});
        end
    endtask

    // Outputs first: a character leaving at the same edge as a new request
    // always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_char_ch.valid && i_char_ch.ready) begin
                if (owed_chars.size() == 0) begin
                    $error("unexpected character %h", i_char_ch.char_code);
                    err_count <= err_count + 1;
                end else begin
                    want = owed_chars.pop_front();
                    if (i_char_ch.char_code !== want.code) begin
                        $error("char_code: expected %h actual %h",
                               want.code, i_char_ch.char_code);
                        err_count <= err_count + 1;
                    end else if (i_char_ch.last_char !== want.is_last) begin
                        $error("last_char: expected %b actual %b",
                               want.is_last, i_char_ch.last_char);
                        err_count <= err_count + 1;
                    end
                end
            end
            if (i_req_ch.valid && i_req_ch.ready) begin
                owe_chars(i_req_ch.req_type, i_req_ch.value);
            end
            pending_count <= owed_chars.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb
    import n2a_pkg::*;
();

    // code 3 is accepted but formats nothing
    localparam logic [1:0] REQ_NONE = 2'd3;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        steady    = 1'b0;
    logic        out_ready = 1'b0;
    int unsigned pending;
    int unsigned errors;
    int unsigned sent;
    int unsigned pick;
    logic [1:0]  kind;
    logic [31:0] val;

    n2a_in_if  req_ch ();
    n2a_out_if char_ch ();

    always #5 i_clk = ~i_clk;

    number_to_ascii_formatter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (char_ch)
    );

    n2a_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_ch  (req_ch),
        .i_char_ch (char_ch),
        .o_pending (pending),
        .o_errors  (errors)
    );

    // Receiver stalls at random, about one time in five, unless in a steady stretch
    assign char_ch.ready = out_ready;
    always @(posedge i_clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // Present one request, sometimes with a random gap first, and hold until taken
    task automatic send_req(input logic [1:0] req, input logic [31:0] num);
        if (!steady && $urandom_range(0, 99) < 20) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= req;
        req_ch.value    <= num;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Let the pending count catch up, then wait for it to drain
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_DEC;
        req_ch.value    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every format, overflow and unused code
        send_req(REQ_DEC, 32'd0);
        send_req(REQ_DEC, 32'hFFFF_FFFF);
        send_req(REQ_DEC, 32'd9);
        send_req(REQ_DEC, 32'd10);
        send_req(REQ_DEC, 32'd999_999_999);
        send_req(REQ_DEC, 32'd1_000_000_000);
        send_req(REQ_HEX, 32'd0);
        send_req(REQ_HEX, 32'hFFFF_FFFF);
        send_req(REQ_HEX, 32'hF);
        send_req(REQ_HEX, 32'h10);
        send_req(REQ_HEX, 32'hABCD_EF01);
        send_req(REQ_FIX, 32'd0);
        send_req(REQ_FIX, 32'd9);
        send_req(REQ_FIX, 32'd10);
        send_req(REQ_FIX, 32'd99);
        send_req(REQ_FIX, 32'd100);
        send_req(REQ_FIX, 32'd999);
        send_req(REQ_FIX, 32'd1000);
        send_req(REQ_FIX, 32'd9999);
        send_req(REQ_FIX, 32'd10000);
        send_req(REQ_FIX, 32'hFFFF_FFFF);
        send_req(REQ_NONE, 32'd0);
        send_req(REQ_NONE, 32'hFFFF_FFFF);
        send_req(REQ_DEC, 32'd1234);

        // random part; requests with the unused code do not count
        sent = 0;
        while (sent < 150) begin
            if (sent == 60) begin
                steady <= 1'b1;
            end
            if (sent == 110) begin
                steady <= 1'b0;
            end
            if (sent == 90) begin
                drain();
            end
            pick = $urandom_range(0, 99);
            kind = (pick < 5) ? REQ_NONE : (pick < 40) ? REQ_DEC :
                   (pick < 70) ? REQ_HEX : REQ_FIX;
            case ($urandom_range(0, 3))
                0: val = $urandom;
                1: val = $urandom >> $urandom_range(0, 31);
                2: val = $urandom_range(0, 12000);
                default: val = $urandom_range(9990, 10010);
            endcase
            send_req(kind, val);
            if (kind != REQ_NONE) begin
                sent = sent + 1;
            end
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
